@@ rtl/obt_pkg.sv @@
package obt_pkg;

	localparam int DEF_NUM_LEVELS = 1024;
	localparam int WORD_W = 32;
	localparam int WORD_SH = 5;
	localparam int KIND_W = 2;
	localparam int PRICE_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [KIND_W-1:0] KIND_BID_SET = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BID_CLR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ASK_SET = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ASK_CLR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_PRICE_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRICE_TOP = 1'b1;

	localparam logic [PRICE_W-1:0] PRICE_BASE_RST = 32'd0;
	localparam logic [PRICE_W-1:0] PRICE_TOP_RST = 32'd1023;

	typedef struct packed {
		logic [PRICE_W-1:0] price_base;
		logic [PRICE_W-1:0] price_top;
	} cfg_t;

	// position of the highest set bit, zero for an empty word
	function automatic logic [WORD_SH-1:0] hi_pos(input logic [WORD_W-1:0] w);
		logic [WORD_SH-1:0] p;
		p = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) p = WORD_SH'(i);
		end
		return p;
	endfunction

	// position of the lowest set bit, zero for an empty word
	function automatic logic [WORD_SH-1:0] lo_pos(input logic [WORD_W-1:0] w);
		logic [WORD_SH-1:0] p;
		p = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) p = WORD_SH'(i);
		end
		return p;
	endfunction

endpackage

@@ rtl/obt_event_if.sv @@
interface obt_event_if;
	logic valid;
	logic ready;
	logic [obt_pkg::KIND_W-1:0] kind;
	logic [obt_pkg::PRICE_W-1:0] price;

	modport source(output valid, output kind, output price, input ready);
	modport sink(input valid, input kind, input price, output ready);
endinterface

@@ rtl/obt_quote_if.sv @@
interface obt_quote_if;
	logic valid;
	logic ready;
	logic best_bid_valid;
	logic [obt_pkg::PRICE_W-1:0] best_bid_price;
	logic best_ask_valid;
	logic [obt_pkg::PRICE_W-1:0] best_ask_price;
	logic out_of_range;

	modport source(output valid, output best_bid_valid, output best_bid_price,
		output best_ask_valid, output best_ask_price, output out_of_range, input ready);
	modport sink(input valid, input best_bid_valid, input best_bid_price,
		input best_ask_valid, input best_ask_price, input out_of_range, output ready);
endinterface

@@ rtl/obt_front.sv @@
module obt_front #(
	parameter int NUM_LEVELS = obt_pkg::DEF_NUM_LEVELS,
	parameter int ENTRY_W = $clog2(NUM_LEVELS) + 3
) (
	input  logic               clk,
	input  logic               arst_n,
	obt_event_if.sink          event_ch,
	input  obt_pkg::cfg_t      cfg,
	output logic               q_valid,
	output logic [ENTRY_W-1:0] q_data,
	input  logic               q_ready
);
	import obt_pkg::*;

	localparam int LVL_W = $clog2(NUM_LEVELS);

	logic               valid_s1;
	logic [ENTRY_W-1:0] data_s1;
	logic [PRICE_W:0]   base_x;
	logic [PRICE_W:0]   lim_x;
	logic [PRICE_W:0]   top_x;
	logic [PRICE_W:0]   top_eff;
	logic [PRICE_W:0]   price_x;
	logic [PRICE_W-1:0] offset;
	logic               oor;
	logic               take;

	// effective top is clipped to the last level of the window
	always_comb begin
		base_x = {1'b0, cfg.price_base};
		lim_x = base_x + (PRICE_W + 1)'(NUM_LEVELS - 1);
		top_x = {1'b0, cfg.price_top};
		top_eff = (top_x < lim_x) ? top_x : lim_x;
		price_x = {1'b0, event_ch.price};
		oor = (price_x < base_x) || (price_x > top_eff);
		offset = event_ch.price - cfg.price_base;
	end

	assign event_ch.ready = !valid_s1 || q_ready;
	assign take = event_ch.valid && event_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= {oor, event_ch.kind, LVL_W'(offset)};
		end
	end

	assign q_valid = valid_s1;
	assign q_data = data_s1;

endmodule

@@ rtl/obt_queue.sv @@
module obt_queue #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop_ready
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/obt_back.sv @@
module obt_back #(
	parameter int NUM_LEVELS = obt_pkg::DEF_NUM_LEVELS,
	parameter int ENTRY_W = $clog2(NUM_LEVELS) + 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  logic [ENTRY_W-1:0]         q_data,
	output logic                       q_ready,
	input  logic [obt_pkg::PRICE_W-1:0] price_base,
	obt_quote_if.source                quote_ch
);
	import obt_pkg::*;

	localparam int LVL_W = $clog2(NUM_LEVELS);
	localparam int R0 = (NUM_LEVELS + WORD_W - 1) / WORD_W;
	localparam int R0_W = (R0 > 1) ? $clog2(R0) : 1;
	localparam int R1 = (R0 + WORD_W - 1) / WORD_W;
	localparam int R1_W = (R1 > 1) ? $clog2(R1) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MOD   = 6'b000010,
		ST_FIND1 = 6'b000100,
		ST_FIND2 = 6'b001000,
		ST_FIND3 = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;

	// leaf rows of presence bits and the row summaries above them
	logic [WORD_W-1:0] l0_bid_mem [R0];
	logic [WORD_W-1:0] l0_ask_mem [R0];
	logic [WORD_W-1:0] l1_bid_mem [R1];
	logic [WORD_W-1:0] l1_ask_mem [R1];
	logic [WORD_W-1:0] l0_bid_rd_q;
	logic [WORD_W-1:0] l0_ask_rd_q;
	logic [WORD_W-1:0] l1_bid_rd_q;
	logic [WORD_W-1:0] l1_ask_rd_q;
	logic [R1-1:0]     l2_bid_q;
	logic [R1-1:0]     l2_ask_q;

	logic [KIND_W-1:0] kind_q;
	logic [LVL_W-1:0]  idx_q;
	logic              oor_q;
	logic [R1_W-1:0]   r1sel_q;
	logic [R0_W-1:0]   r0sel_q;
	logic              bid_ok_q;
	logic [LVL_W-1:0]  bid_idx_q;
	logic              ask_ok_q;
	logic [LVL_W-1:0]  ask_idx_q;

	logic              out_valid_q;
	logic              out_bid_valid_q;
	logic [PRICE_W-1:0] out_bid_price_q;
	logic              out_ask_valid_q;
	logic [PRICE_W-1:0] out_ask_price_q;
	logic              out_oor_q;

	logic [LVL_W-1:0]  q_idx;
	logic [KIND_W-1:0] q_kind;
	logic              q_oor;
	logic              pop;
	logic              side_ask;
	logic              set_bit;
	logic [R0_W-1:0]   r0_q;
	logic [R1_W-1:0]   r1_q;
	logic [R0_W-1:0]   rd_addr0;
	logic [R1_W-1:0]   rd_addr1;
	logic [WORD_W-1:0] l1_old;
	logic [WORD_W-1:0] l0_old;
	logic [WORD_W-1:0] row0_new;
	logic [WORD_W-1:0] row1_new;
	logic [WORD_W-1:0] mask0;
	logic [WORD_W-1:0] mask1;
	logic [R1-1:0]     l2_side;
	logic              wr_bid;
	logic              wr_ask;
	logic [R1_W-1:0]   l2_hi;
	logic [R1_W-1:0]   l2_lo;
	logic              l2_any;
	logic [R1_W-1:0]   r1sel;
	logic [WORD_W-1:0] row1_rd;
	logic [WORD_W-1:0] row0_rd;
	logic [WORD_SH-1:0] pos1;
	logic [WORD_SH-1:0] pos0;
	logic [R0_W-1:0]   r0sel;
	logic [LVL_W-1:0]  best_idx;
	logic              emit;

	assign {q_oor, q_kind, q_idx} = q_data;
	assign q_ready = (state_q == ST_IDLE);
	assign pop = q_valid && q_ready;

	assign side_ask = kind_q[1];
	assign set_bit = (kind_q == KIND_BID_SET) || (kind_q == KIND_ASK_SET);
	assign r0_q = R0_W'(32'(idx_q) >> WORD_SH);
	assign r1_q = R1_W'(32'(r0_q) >> WORD_SH);

	// read-modify-write of one leaf row and its summary row
	always_comb begin
		l2_side = side_ask ? l2_ask_q : l2_bid_q;
		l1_old = l2_side[r1_q] ? (side_ask ? l1_ask_rd_q : l1_bid_rd_q) : '0;
		l0_old = l1_old[WORD_SH'(32'(r0_q))] ? (side_ask ? l0_ask_rd_q : l0_bid_rd_q) : '0;
		mask0 = WORD_W'(1) << WORD_SH'(32'(idx_q));
		mask1 = WORD_W'(1) << WORD_SH'(32'(r0_q));
		row0_new = set_bit ? (l0_old | mask0) : (l0_old & ~mask0);
		row1_new = (|row0_new) ? (l1_old | mask1) : (l1_old & ~mask1);
	end

	assign wr_bid = (state_q == ST_MOD) && !side_ask;
	assign wr_ask = (state_q == ST_MOD) && side_ask;

	// top summary: highest set bid row group, lowest set ask row group
	always_comb begin
		l2_hi = '0;
		l2_lo = '0;
		for (int i = 0; i < R1; i++) begin
			if (l2_bid_q[i]) l2_hi = R1_W'(i);
		end
		for (int i = R1 - 1; i >= 0; i--) begin
			if (l2_ask_q[i]) l2_lo = R1_W'(i);
		end
		l2_any = side_ask ? (|l2_ask_q) : (|l2_bid_q);
		r1sel = side_ask ? l2_lo : l2_hi;
	end

	always_comb begin
		row1_rd = side_ask ? l1_ask_rd_q : l1_bid_rd_q;
		row0_rd = side_ask ? l0_ask_rd_q : l0_bid_rd_q;
		pos1 = side_ask ? lo_pos(row1_rd) : hi_pos(row1_rd);
		pos0 = side_ask ? lo_pos(row0_rd) : hi_pos(row0_rd);
		r0sel = R0_W'((32'(r1sel_q) << WORD_SH) | 32'(pos1));
		best_idx = LVL_W'((32'(r0sel_q) << WORD_SH) | 32'(pos0));
	end

	always_comb begin
		rd_addr0 = r0_q;
		rd_addr1 = r1_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr0 = R0_W'(32'(q_idx) >> WORD_SH);
				rd_addr1 = R1_W'(32'(q_idx) >> (2 * WORD_SH));
			end
			ST_FIND1: rd_addr1 = r1sel;
			ST_FIND2: rd_addr0 = r0sel;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_bid) begin
			l0_bid_mem[r0_q] <= row0_new;
		end
		l0_bid_rd_q <= l0_bid_mem[rd_addr0];
	end

	always_ff @(posedge clk) begin
		if (wr_ask) begin
			l0_ask_mem[r0_q] <= row0_new;
		end
		l0_ask_rd_q <= l0_ask_mem[rd_addr0];
	end

	always_ff @(posedge clk) begin
		if (wr_bid) begin
			l1_bid_mem[r1_q] <= row1_new;
		end
		l1_bid_rd_q <= l1_bid_mem[rd_addr1];
	end

	always_ff @(posedge clk) begin
		if (wr_ask) begin
			l1_ask_mem[r1_q] <= row1_new;
		end
		l1_ask_rd_q <= l1_ask_mem[rd_addr1];
	end

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || quote_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			l2_bid_q <= '0;
			l2_ask_q <= '0;
			bid_ok_q <= 1'b0;
			ask_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= q_oor ? ST_EMIT : ST_MOD;
					end
				end
				ST_MOD: begin
					if (side_ask) begin
						l2_ask_q[r1_q] <= |row1_new;
					end else begin
						l2_bid_q[r1_q] <= |row1_new;
					end
					state_q <= ST_FIND1;
				end
				ST_FIND1: begin
					if (l2_any) begin
						state_q <= ST_FIND2;
					end else begin
						if (side_ask) begin
							ask_ok_q <= 1'b0;
						end else begin
							bid_ok_q <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_FIND2: state_q <= ST_FIND3;
				ST_FIND3: begin
					if (side_ask) begin
						ask_ok_q <= 1'b1;
					end else begin
						bid_ok_q <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (quote_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_kind;
			idx_q <= q_idx;
			oor_q <= q_oor;
		end
		if (state_q == ST_FIND1) begin
			r1sel_q <= r1sel;
		end
		if (state_q == ST_FIND2) begin
			r0sel_q <= r0sel;
		end
		if (state_q == ST_FIND3) begin
			if (side_ask) begin
				ask_idx_q <= best_idx;
			end else begin
				bid_idx_q <= best_idx;
			end
		end
		if (emit) begin
			out_bid_valid_q <= bid_ok_q;
			out_bid_price_q <= bid_ok_q ? (price_base + PRICE_W'(bid_idx_q)) : '0;
			out_ask_valid_q <= ask_ok_q;
			out_ask_price_q <= ask_ok_q ? (price_base + PRICE_W'(ask_idx_q)) : '0;
			out_oor_q <= oor_q;
		end
	end

	assign quote_ch.valid = out_valid_q;
	assign quote_ch.best_bid_valid = out_bid_valid_q;
	assign quote_ch.best_bid_price = out_bid_price_q;
	assign quote_ch.best_ask_valid = out_ask_valid_q;
	assign quote_ch.best_ask_price = out_ask_price_q;
	assign quote_ch.out_of_range = out_oor_q;

endmodule

@@ rtl/order_book_best_price_tracker_core.sv @@
// Best bid / best ask tracker over a window of NUM_LEVELS price ticks starting at
// price_base. Each in-range event transfer sets or clears one level's bid or ask
// presence, and every event transfer yields exactly one quote transfer carrying
// the current best bid (highest present bid), best ask (lowest present ask) and
// an out-of-range flag. A front stage range-checks the price and hands the level
// index through a two-entry queue to the bitmap engine, which for an in-range
// event reads leaf and summary rows, writes them back, then searches the summary
// bits, group row and leaf row in turn (stopping at the summary bits when that
// side is empty), the group and leaf rows each a registered memory read; an
// out-of-range event goes straight to the quote. The engine works on one event at
// a time, so its read-modify-write and search set the rate. Presence
// is kept as leaf words of 32 levels with summary bits above them; a summary bit
// marks its row valid, so no clearing pass runs after reset and events are taken
// at once. Write price_base and price_top only while no event is in flight.
module order_book_best_price_tracker_core #(
	parameter int NUM_LEVELS = obt_pkg::DEF_NUM_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	obt_event_if.sink                     event_ch,
	obt_quote_if.source                   quote_ch,
	input  logic                          cfg_we,
	input  logic [obt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [obt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import obt_pkg::*;

	localparam int ENTRY_W = $clog2(NUM_LEVELS) + 3;

	cfg_t               cfg_q;
	logic               q_in_valid;
	logic [ENTRY_W-1:0] q_in_data;
	logic               q_in_ready;
	logic               q_out_valid;
	logic [ENTRY_W-1:0] q_out_data;
	logic               q_out_ready;
	logic [2:0]         inflight_q;
	logic               ev_xfer;
	logic               qt_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.price_base <= PRICE_BASE_RST;
			cfg_q.price_top <= PRICE_TOP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRICE_BASE: cfg_q.price_base <= PRICE_W'(cfg_data);
				CFG_PRICE_TOP: cfg_q.price_top <= PRICE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	obt_front #(
		.NUM_LEVELS(NUM_LEVELS),
		.ENTRY_W(ENTRY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.event_ch(event_ch),
		.cfg(cfg_q),
		.q_valid(q_in_valid),
		.q_data(q_in_data),
		.q_ready(q_in_ready)
	);

	obt_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(q_in_valid),
		.push_data(q_in_data),
		.push_ready(q_in_ready),
		.pop_valid(q_out_valid),
		.pop_data(q_out_data),
		.pop_ready(q_out_ready)
	);

	obt_back #(
		.NUM_LEVELS(NUM_LEVELS),
		.ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_out_valid),
		.q_data(q_out_data),
		.q_ready(q_out_ready),
		.price_base(cfg_q.price_base),
		.quote_ch(quote_ch)
	);

	// events held between front stage, queue, engine and quote register
	assign ev_xfer = event_ch.valid && event_ch.ready;
	assign qt_xfer = quote_ch.valid && quote_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (ev_xfer && !qt_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (qt_xfer && !ev_xfer) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd5)
		else $error("more events in flight than the pipeline can hold");

	a_quote_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		quote_ch.valid |-> inflight_q != 3'd0)
		else $error("quote offered with no event outstanding");

	a_empty_bid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quote_ch.valid && !quote_ch.best_bid_valid |-> quote_ch.best_bid_price == '0)
		else $error("best bid price non-zero with no bid present");

	a_empty_ask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		quote_ch.valid && !quote_ch.best_ask_valid |-> quote_ch.best_ask_price == '0)
		else $error("best ask price non-zero with no ask present");

endmodule
